// ===== design/sbca_pkg.sv =====
package sbca_pkg;

  localparam int CHUNK_BYTES_DEF     = 16384;
  localparam int MAX_CHUNKS_DEF      = 16;
  localparam int MAX_BLOCK_BYTES_DEF = 640;
  localparam int NUM_CLASSES_DEF     = 14;

  localparam int CLASS_MAX = 14;

  // class sizes in 16-byte granules: 16, 32, 64, 96, 128, 160, 192, 224, 256, 320, 384,
  // 448, 512, 640 bytes
  localparam logic [5:0] CLASS_GRAN [CLASS_MAX] = '{
    6'd1, 6'd2, 6'd4, 6'd6, 6'd8, 6'd10, 6'd12,
    6'd14, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40
  };

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO      = 2'd1;
  localparam logic [1:0] STAT_OVERSIZE  = 2'd2;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_EXEC,
    ST_POP,
    ST_CARVE,
    ST_DONE
  } state_t;

endpackage

// ===== design/sbca_link_ram.sv =====
module sbca_link_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/size_class_block_allocator.sv =====
// Size-class block allocator over a pool of MAX_CHUNKS chunks of CHUNK_BYTES bytes.
// Input stream: one transaction per request. in_tuser = mode (alloc, free, clear, nop);
// in_tdata = size, address. Output stream: one transaction per request with the
// block offset in out_tdata and the status code in out_tuser.
// Timing: one request at a time; in_tready is high only while idle. An accepted
// request passes through the class lookup and execute states, then the pop state
// for a pop from a class free list (one link RAM read), or the carve state when a
// fresh chunk is carved (one link RAM write per block, N = CHUNK_BYTES / class
// size blocks, up to 1024 with the default chunk), and ends in the done state.
// The block is back in idle on the edge that loads the result, so a new request
// is taken only once the last result is loaded. The per-cycle work of carving runs
// on one adder/compare stepping through the chunk's blocks.
// Reset clears all class heads and the chunk count; the link RAM needs no clear.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and processed, and its result waits until the register frees.
module size_class_block_allocator #(
  parameter int CHUNK_BYTES     = sbca_pkg::CHUNK_BYTES_DEF,
  parameter int MAX_CHUNKS      = sbca_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_BLOCK_BYTES = sbca_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int NUM_CLASSES     = sbca_pkg::NUM_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] size, [33:16] address, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [17:0] block_address, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int POOL_BYTES = MAX_CHUNKS * CHUNK_BYTES;
  localparam int GRANULES   = POOL_BYTES / 16;
  localparam int CHUNK_GRAN = CHUNK_BYTES / 16;
  localparam int GW         = $clog2(GRANULES);
  localparam int LW         = $clog2(GRANULES + 1);
  localparam int XW         = $clog2(GRANULES + 128);
  localparam int CUW        = $clog2(MAX_CHUNKS + 1);
  localparam int CLW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  sbca_pkg::state_t state_r, state_nxt;

  logic [1:0]     mode_r, mode_nxt;
  logic [15:0]    size_r, size_nxt;
  logic [17:0]    addr_r, addr_nxt;
  logic [CLW-1:0] cls_r, cls_nxt;
  logic           hit_r, hit_nxt;
  logic [5:0]     bsg_r, bsg_nxt;
  logic [LW-1:0]  heads_r [NUM_CLASSES];
  logic [LW-1:0]  heads_nxt [NUM_CLASSES];
  logic [CUW-1:0] chunks_r, chunks_nxt;
  logic [XW-1:0]  base_r, base_nxt;
  logic [XW-1:0]  cur_r, cur_nxt;
  logic [XW-1:0]  nxt_r, nxt_nxt;
  logic [XW-1:0]  lim_r, lim_nxt;
  logic [17:0]    res_addr_r, res_addr_nxt;
  logic [1:0]     res_stat_r, res_stat_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [17:0]    out_addr_r, out_addr_nxt;
  logic [1:0]     out_stat_r, out_stat_nxt;

  logic           ram_we;
  logic [GW-1:0]  ram_waddr;
  logic [LW-1:0]  ram_wdata;
  logic [GW-1:0]  ram_raddr;
  logic [LW-1:0]  ram_rdata;

  logic [CLW-1:0] cls_c;
  logic           hit_c;
  logic [5:0]     bsg_c;
  logic [LW-1:0]  head;
  logic [LW-1:0]  head_m1;
  logic [GW-1:0]  free_g;
  logic           free_ok;
  logic [XW-1:0]  step_sum;

  sbca_link_ram #(
    .DEPTH (GRANULES),
    .AW    (GW),
    .DW    (LW)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // smallest class that holds the size
  always_comb begin
    cls_c = '0;
    hit_c = 1'b0;
    bsg_c = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size_r <= 16'({sbca_pkg::CLASS_GRAN[c], 4'b0000})) begin
        cls_c = CLW'(c);
        hit_c = 1'b1;
        bsg_c = sbca_pkg::CLASS_GRAN[c];
      end
    end
    if (size_r > 16'(MAX_BLOCK_BYTES)) begin
      hit_c = 1'b0;
    end
  end

  assign head     = heads_r[cls_r];
  assign head_m1  = head - LW'(1);
  assign free_g   = GW'(addr_r >> 4);
  assign free_ok  = 32'(addr_r) < 32'(POOL_BYTES);
  assign step_sum = nxt_r + XW'(bsg_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    cls_nxt       = cls_r;
    hit_nxt       = hit_r;
    bsg_nxt       = bsg_r;
    heads_nxt     = heads_r;
    chunks_nxt    = chunks_r;
    base_nxt      = base_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    lim_nxt       = lim_r;
    res_addr_nxt  = res_addr_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = GW'(cur_r);
    ram_wdata     = '0;
    ram_raddr     = GW'(head_m1);

    unique case (state_r)
      sbca_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt     = in_tuser;
          size_nxt     = in_tdata[15:0];
          addr_nxt     = in_tdata[33:16];
          res_addr_nxt = '0;
          res_stat_nxt = sbca_pkg::STAT_OK;
          state_nxt    = sbca_pkg::ST_CLASS;
        end
      end

      sbca_pkg::ST_CLASS: begin
        cls_nxt   = cls_c;
        hit_nxt   = hit_c;
        bsg_nxt   = bsg_c;
        state_nxt = sbca_pkg::ST_EXEC;
      end

      sbca_pkg::ST_EXEC: begin
        state_nxt = sbca_pkg::ST_DONE;
        if (mode_r == sbca_pkg::MODE_ALLOC || mode_r == sbca_pkg::MODE_FREE) begin
          if (size_r == '0) begin
            res_stat_nxt = sbca_pkg::STAT_ZERO;
          end else if (!hit_r) begin
            res_stat_nxt = sbca_pkg::STAT_OVERSIZE;
          end else if (mode_r == sbca_pkg::MODE_ALLOC) begin
            if (head != '0) begin
              res_addr_nxt = 18'({head_m1, 4'b0000});
              state_nxt    = sbca_pkg::ST_POP;
            end else if (chunks_r >= CUW'(MAX_CHUNKS)) begin
              res_stat_nxt = sbca_pkg::STAT_EXHAUSTED;
            end else begin
              res_addr_nxt = 18'({base_r, 4'b0000});
              cur_nxt      = base_r;
              nxt_nxt      = base_r + XW'(bsg_r);
              lim_nxt      = base_r + XW'(CHUNK_GRAN);
              if (XW'(bsg_r) + XW'(bsg_r) <= XW'(CHUNK_GRAN)) begin
                heads_nxt[cls_r] = LW'(base_r + XW'(bsg_r) + XW'(1));
              end else begin
                heads_nxt[cls_r] = '0;
              end
              base_nxt   = base_r + XW'(CHUNK_GRAN);
              chunks_nxt = chunks_r + CUW'(1);
              state_nxt  = sbca_pkg::ST_CARVE;
            end
          end else if (free_ok) begin
            ram_we           = 1'b1;
            ram_waddr        = free_g;
            ram_wdata        = head;
            heads_nxt[cls_r] = LW'(free_g) + LW'(1);
          end
        end else if (mode_r == sbca_pkg::MODE_CLEAR) begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            heads_nxt[c] = '0;
          end
          chunks_nxt = '0;
          base_nxt   = '0;
        end
      end

      sbca_pkg::ST_POP: begin
        heads_nxt[cls_r] = ram_rdata;
        state_nxt        = sbca_pkg::ST_DONE;
      end

      sbca_pkg::ST_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = GW'(cur_r);
        if (step_sum <= lim_r) begin
          ram_wdata = LW'(nxt_r + XW'(1));
          cur_nxt   = nxt_r;
          nxt_nxt   = step_sum;
        end else begin
          ram_wdata = '0;
          state_nxt = sbca_pkg::ST_DONE;
        end
      end

      sbca_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = sbca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sbca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      chunks_r    <= '0;
      base_r      <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chunks_r    <= chunks_nxt;
      base_r      <= base_nxt;
      heads_r     <= heads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    cls_r      <= cls_nxt;
    hit_r      <= hit_nxt;
    bsg_r      <= bsg_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    lim_r      <= lim_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_addr_r};
  assign out_tuser  = out_stat_r;

endmodule

// ===== test/size_class_block_allocator_tb.sv =====
module size_class_block_allocator_tb;

  localparam int CHUNK      = sbca_pkg::CHUNK_BYTES_DEF;
  localparam int CHUNKS     = sbca_pkg::MAX_CHUNKS_DEF;
  localparam int BLOCK_MAX  = sbca_pkg::MAX_BLOCK_BYTES_DEF;
  localparam int CLASSES    = sbca_pkg::NUM_CLASSES_DEF;
  localparam int POOL       = CHUNK * CHUNKS;
  localparam int GRANULES   = POOL / 16;
  localparam int RAND_ITEMS = 525;
  localparam int LONG_HOLD  = 400;
  localparam int WATCHDOG   = 10000;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] nbytes;
    logic [17:0] address;
    bit          typed;
    logic [17:0] exp_addr;
    logic [1:0]  exp_status;
  } req_t;

  typedef struct {
    logic [17:0] addr;
    logic [1:0]  status;
  } grant_t;

  typedef struct {
    logic [17:0] addr;
    logic [15:0] nbytes;
  } held_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [15:0] size, [33:16] address, rest zero
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [17:0] block_address, rest zero
  logic [1:0]  out_tuser;  // [1:0] status

  size_class_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // allocator shadow: heads and links hold granule + 1, zero is null
  int unsigned class_heads [CLASSES];
  int unsigned granule_links [GRANULES];
  int unsigned chunks_carved;

  grant_t due_grants [$];
  held_t  held_blocks [$];
  req_t   plan [$];

  int  errors;
  int  quiet_cycles;
  bit  quiet;
  bit  hold_now;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned class_index(input int unsigned nbytes);
    if (nbytes > BLOCK_MAX) return CLASSES;
    for (int c = 0; c < CLASSES; c++)
      if (nbytes <= sbca_pkg::CLASS_GRAN[c] * 16) return c;
    return CLASSES;
  endfunction

  task automatic compute_grant(input req_t r, output grant_t g);
    int unsigned cls, gi, bs, cnt, base;
    g.addr   = '0;
    g.status = sbca_pkg::STAT_OK;
    if (r.mode == sbca_pkg::MODE_ALLOC || r.mode == sbca_pkg::MODE_FREE) begin
      cls = class_index(r.nbytes);
      if (r.nbytes == 0) begin
        g.status = sbca_pkg::STAT_ZERO;
      end else if (cls >= CLASSES) begin
        g.status = sbca_pkg::STAT_OVERSIZE;
      end else if (r.mode == sbca_pkg::MODE_ALLOC) begin
        if (class_heads[cls] != 0) begin
          gi = class_heads[cls] - 1;
          class_heads[cls] = granule_links[gi];
          g.addr = 18'(gi * 16);
        end else if (chunks_carved >= CHUNKS) begin
          g.status = sbca_pkg::STAT_EXHAUSTED;
        end else begin
          bs   = sbca_pkg::CLASS_GRAN[cls] * 16;
          cnt  = CHUNK / bs;
          base = chunks_carved * CHUNK;
          for (int unsigned i = 0; i < cnt; i++)
            granule_links[(base + bs * i) / 16] =
              (i + 1 < cnt) ? (base + bs * (i + 1)) / 16 + 1 : 0;
          class_heads[cls] = (cnt > 1) ? (base + bs) / 16 + 1 : 0;
          chunks_carved++;
          g.addr = 18'(base);
        end
        if (g.status == sbca_pkg::STAT_OK) held_blocks.push_back('{g.addr, r.nbytes});
      end else if (r.address < POOL) begin
        gi = r.address / 16;
        granule_links[gi] = class_heads[cls];
        class_heads[cls] = gi + 1;
      end
    end else if (r.mode == sbca_pkg::MODE_CLEAR) begin
      foreach (class_heads[c]) class_heads[c] = 0;
      chunks_carved = 0;
      held_blocks.delete();
    end
  endtask

  task automatic add_row(input logic [1:0] mode, input int unsigned nbytes,
                         input int unsigned address, input bit typed,
                         input int unsigned exp_addr, input logic [1:0] exp_status);
    req_t r;
    r.mode       = mode;
    r.nbytes     = 16'(nbytes);
    r.address    = 18'(address);
    r.typed      = typed;
    r.exp_addr   = 18'(exp_addr);
    r.exp_status = exp_status;
    plan.push_back(r);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic push_req(input req_t r);
    grant_t g;
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {6'b0, r.address, r.nbytes};
    do @(posedge clk); while (!in_tready);
    compute_grant(r, g);
    if (r.typed) begin
      g.addr   = r.exp_addr;
      g.status = r.exp_status;
    end
    due_grants.push_back(g);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (due_grants.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_alloc_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return 16'($urandom_range(1, BLOCK_MAX));
    if (k < 85) return 16'($urandom_range(449, BLOCK_MAX));
    return 16'(sbca_pkg::CLASS_GRAN[$urandom_range(0, sbca_pkg::CLASS_MAX - 1)] * 16
               + $urandom_range(0, 1));
  endfunction

  task automatic random_req(output req_t r);
    int unsigned pick, idx;
    r.typed      = 1'b0;
    r.exp_addr   = '0;
    r.exp_status = sbca_pkg::STAT_OK;
    r.mode       = sbca_pkg::MODE_ALLOC;
    r.nbytes     = pick_alloc_size();
    r.address    = 18'($urandom_range(0, 262143));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
    end else if (pick < 68) begin
      if (held_blocks.size() != 0) begin
        idx = $urandom_range(0, held_blocks.size() - 1);
        r.mode    = sbca_pkg::MODE_FREE;
        r.nbytes  = held_blocks[idx].nbytes;
        r.address = held_blocks[idx].addr | 18'($urandom_range(0, 3) == 0 ?
                                                $urandom_range(0, 15) : 0);
        held_blocks.delete(idx);
      end
    end else if (pick < 75) begin
      r.mode   = sbca_pkg::MODE_FREE;
      r.nbytes = 16'($urandom_range(1, BLOCK_MAX));
    end else if (pick < 79) begin
      r.mode   = $urandom_range(0, 1) ? sbca_pkg::MODE_FREE : sbca_pkg::MODE_ALLOC;
      r.nbytes = '0;
    end else if (pick < 85) begin
      r.mode   = $urandom_range(0, 1) ? sbca_pkg::MODE_FREE : sbca_pkg::MODE_ALLOC;
      r.nbytes = 16'($urandom_range(BLOCK_MAX + 1, 65535));
    end else if (pick < 89) begin
      r.mode   = sbca_pkg::MODE_NOP;
      r.nbytes = 16'($urandom_range(0, 65535));
    end else if (pick < 90) begin
      r.mode   = sbca_pkg::MODE_CLEAR;
      r.nbytes = 16'($urandom_range(0, 65535));
    end else begin
      r.nbytes = 16'($urandom_range(449, BLOCK_MAX));
    end
  endtask

  // receiver
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_grants.size() == 0) begin
        $error("unexpected result: block_address %0d status %0d",
               out_tdata[17:0], out_tuser);
        errors++;
      end else begin
        g = due_grants.pop_front();
        if (out_tdata[17:0] !== g.addr) begin
          $error("block_address: expected %0d, got %0d", g.addr, out_tdata[17:0]);
          errors++;
        end
        if (out_tuser !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_t r;
    int   done;
    errors        = 0;
    quiet         = 1'b0;
    hold_now      = 1'b0;
    quiet_cycles  = 0;
    chunks_carved = 0;
    foreach (class_heads[c]) class_heads[c] = 0;
    foreach (granule_links[i]) granule_links[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= sbca_pkg::MODE_ALLOC;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row(sbca_pkg::MODE_ALLOC, 16,    0,      1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 1,     0,      1, 16,     sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 17,    0,      1, 16384,  sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 640,   0,      1, 32768,  sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 0,     0,      1, 0,      sbca_pkg::STAT_ZERO);
    add_row(sbca_pkg::MODE_FREE,  0,     12345,  1, 0,      sbca_pkg::STAT_ZERO);
    add_row(sbca_pkg::MODE_ALLOC, 641,   0,      1, 0,      sbca_pkg::STAT_OVERSIZE);
    add_row(sbca_pkg::MODE_FREE,  65535, 262143, 1, 0,      sbca_pkg::STAT_OVERSIZE);
    add_row(sbca_pkg::MODE_NOP,   100,   262143, 1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_FREE,  16,    16,     1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 16,    0,      1, 16,     sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_FREE,  640,   262143, 1, 0,      sbca_pkg::STAT_OK);  // unaligned, last granule
    add_row(sbca_pkg::MODE_ALLOC, 600,   0,      1, 262128, sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 640,   0,      1, 33408,  sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_FREE,  20,    5,      1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 32,    0,      1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_CLEAR, 0,     0,      1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 640,   0,      1, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 48,    0,      0, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 96,    0,      0, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 160,   0,      0, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 256,   0,      0, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 320,   0,      0, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 448,   0,      0, 0,      sbca_pkg::STAT_OK);
    add_row(sbca_pkg::MODE_ALLOC, 512,   0,      0, 0,      sbca_pkg::STAT_OK);
    foreach (plan[i]) push_req(plan[i]);
    drain();

    done = 0;
    while (done < RAND_ITEMS) begin
      if (done == 100 || done == 400) drain();
      if (done == 150) hold_now = 1'b1;
      quiet = (done >= 250 && done < 370);
      random_req(r);
      push_req(r);
      done++;
    end
    quiet = 1'b0;

    in_tvalid <= 1'b0;
    while (due_grants.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && due_grants.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sbca_pkg.sv
design/sbca_link_ram.sv
design/size_class_block_allocator.sv
test/size_class_block_allocator_tb.sv
